[rtl/affa_pkg.sv]
// Shared types and constants of the aligned first-fit chunk allocator.
package affa_pkg;

  localparam int unsigned BANKS_DEF       = 4;
  localparam int unsigned MAX_RECORDS_DEF = 1024;
  localparam int unsigned CFG_BANKS       = 4;   // register file always holds four banks
  localparam int unsigned AW              = 34;  // width of byte sums and compares
  localparam int unsigned DV_W            = 20;  // divisor / remainder width
  localparam int unsigned CFG_IDX_W       = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_B0_START = 4'd0,
    CFG_B0_END   = 4'd1,
    CFG_B1_START = 4'd2,
    CFG_B1_END   = 4'd3,
    CFG_B2_START = 4'd4,
    CFG_B2_END   = 4'd5,
    CFG_B3_START = 4'd6,
    CFG_B3_END   = 4'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FAIL   = 2'd1,
    ST_NOBANK = 2'd2
  } status_e;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] size_bytes;
    logic [1:0]  bank;
    logic [16:0] alignment;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data_address;
  } rsp_t;

  typedef struct packed {
    logic            start;
    logic [AW-1:0]   dividend;
    logic [DV_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic            done;
    logic [DV_W-1:0] rem;
  } mod_rsp_t;

endpackage

[rtl/aligned_first_fit_chunk_allocator.sv]
// Top level: request sequencer, chunk header memories and bank registers.
//
//   channel | signals                              | direction
//   in      | in_valid_i / in_ready_o / in_req_i   | request in
//   out     | out_valid_o / out_ready_i / out_rsp_o| one response per request
//   cfg     | cfg_valid_i / cfg_ready_o / index,data| bank register write
//
// One request at a time. Each remainder use starts the serial unit and waits for its done.
// Allocate tries the first slot, then the space after the last chunk, then walks the
// gaps between chunks until one fits.
// Free walks the links to the chunk before it; a middle chunk is unlinked by copying its link.
// Chunk memories give one registered read per cycle.
// No clearing pass after reset; headers are defined once written.
// The response register lets a result wait while the next request is taken.
module aligned_first_fit_chunk_allocator import affa_pkg::*; #(
  parameter int unsigned BANKS       = BANKS_DEF,
  parameter int unsigned MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  req_t                 in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rsp_t                 out_rsp_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  localparam int unsigned RW    = $clog2(MAX_RECORDS);
  localparam int unsigned NW    = RW + 1;
  localparam int unsigned IW    = RW + 2;
  localparam int unsigned BW    = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam int unsigned DEPTH = BANKS * MAX_RECORDS;
  localparam int unsigned MA_W  = $clog2(DEPTH);
  localparam int unsigned TW    = 29;

  typedef enum logic [16:0] {
    S_IDLE      = 17'h00001,
    S_DECODE    = 17'h00002,
    S_MODW      = 17'h00004,
    S_NEED      = 17'h00008,
    S_CHK_FIRST = 17'h00010,
    S_RD_LAST   = 17'h00020,
    S_LAST_DAT  = 17'h00040,
    S_CHK_LAST  = 17'h00080,
    S_WLK_RD    = 17'h00100,
    S_WLK_DAT   = 17'h00200,
    S_CHK_GAP   = 17'h00400,
    S_GAP_WR2   = 17'h00800,
    S_FW_RD     = 17'h01000,
    S_FW_DAT    = 17'h02000,
    S_FT_RD     = 17'h04000,
    S_FT_DAT    = 17'h08000,
    S_DONE      = 17'h10000
  } state_e;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_LAST  = 2'd1,
    PH_GAP   = 2'd2
  } phase_e;

  function automatic logic [MA_W-1:0] slot(input logic [BW-1:0] b, input logic [RW-1:0] i);
    return MA_W'(MA_W'(b) * MA_W'(MAX_RECORDS) + MA_W'(i));
  endfunction

  // bank registers
  logic [31:0] bstart_q [CFG_BANKS];
  logic [31:0] bend_q   [CFG_BANKS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CFG_BANKS; k++) begin
        bstart_q[k] <= '0;
        bend_q[k]   <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_B0_START: bstart_q[0] <= cfg_data_i;
        CFG_B0_END:   bend_q[0]   <= cfg_data_i;
        CFG_B1_START: bstart_q[1] <= cfg_data_i;
        CFG_B1_END:   bend_q[1]   <= cfg_data_i;
        CFG_B2_START: bstart_q[2] <= cfg_data_i;
        CFG_B2_END:   bend_q[2]   <= cfg_data_i;
        CFG_B3_START: bstart_q[3] <= cfg_data_i;
        CFG_B3_END:   bend_q[3]   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // sequencer state
  state_e          state_q, state_d;
  phase_e          phase_q, phase_d;
  req_t            req_q, req_d;
  logic [BW-1:0]   bank_q, bank_d;
  logic [31:0]     start_q, start_d;
  logic [NW-1:0]   nrec_q, nrec_d;
  logic [DV_W-1:0] align_q, align_d;
  logic [29:0]     srec_q, srec_d;
  logic [AW-1:0]   need_q, need_d;
  logic [16:0]     exr_q, exr_d;
  logic [IW-1:0]   ls_q, ls_d;
  logic [RW-1:0]   cur_q, cur_d, nxt_q, nxt_d, idx_q, idx_d;
  logic [NW-1:0]   cnt_q, cnt_d;
  logic [TW-1:0]   target_q, target_d;
  logic            tf_q, tf_d;
  status_e         rstat_q, rstat_d;
  logic [31:0]     raddr_q, raddr_d;
  logic            out_valid_q, out_valid_d;
  rsp_t            out_rsp_q, out_rsp_d;
  logic            used_q  [BANKS];
  logic            used_d  [BANKS];
  logic [RW-1:0]   first_q [BANKS];
  logic [RW-1:0]   first_d [BANKS];
  logic [RW-1:0]   last_q  [BANKS];
  logic [RW-1:0]   last_d  [BANKS];

  // chunk header memories
  logic [RW-1:0]   next_mem [DEPTH];
  logic [NW-1:0]   size_mem [DEPTH];
  logic            next_we, size_we;
  logic [MA_W-1:0] next_wa, next_ra, size_wa, size_ra;
  logic [RW-1:0]   next_wd, next_rd_q;
  logic [NW-1:0]   size_wd, size_rd_q;

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd_q <= next_mem[next_ra];
    if (size_we) size_mem[size_wa] <= size_wd;
    size_rd_q <= size_mem[size_ra];
  end

  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  affa_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  // bank lookup for a free: lowest numbered bank holding the address
  logic          hit;
  logic [BW-1:0] hit_b;

  always_comb begin
    hit   = 1'b0;
    hit_b = '0;
    for (int b = BANKS - 1; b >= 0; b--) begin
      if (bstart_q[b] <= req_q.address && bend_q[b] > req_q.address) begin
        hit   = 1'b1;
        hit_b = BW'(b);
      end
    end
  end

  logic [BW-1:0]   bk;
  logic [31:0]     bk_start, bk_end, diff, off;
  logic [28:0]     rec;
  logic [NW-1:0]   nrec_w;
  logic [16:0]     a17;
  logic [DV_W-1:0] align_w, ex_w;
  logic [29:0]     srec_w;
  logic [AW-1:0]   sz_w, space_last, space_gap;
  logic            used_b;
  logic [RW-1:0]   first_b, last_b, idx_w;
  logic [NW-1:0]   srec1;

  always_comb begin
    if (state_q == S_DECODE) begin
      bk = (req_q.req_type == REQ_FREE) ? hit_b : req_q.bank[BW-1:0];
    end else begin
      bk = bank_q;
    end
    bk_start = bstart_q[2'(bk)];
    bk_end   = bend_q[2'(bk)];
    diff     = bk_end - bk_start;
    rec      = diff[31:3];
    if (bk_end <= bk_start) begin
      nrec_w = '0;
    end else if (32'(rec) > MAX_RECORDS) begin
      nrec_w = NW'(MAX_RECORDS);
    end else begin
      nrec_w = NW'(rec);
    end
    off = req_q.address - bk_start;

    a17 = (req_q.alignment == '0) ? 17'd1 : req_q.alignment;
    // lcm with the record size follows from the low bits
    if (a17[2:0] == 3'd0) begin
      align_w = DV_W'(a17);
    end else if (a17[1:0] == 2'd0) begin
      align_w = DV_W'(a17) << 1;
    end else if (a17[0] == 1'b0) begin
      align_w = DV_W'(a17) << 2;
    end else begin
      align_w = DV_W'(a17) << 3;
    end
    srec_w = 30'((33'(req_q.size_bytes) + 33'd7) >> 3);

    sz_w  = AW'(srec_q) << 3;
    ex_w  = (mod_rsp.rem != '0) ? align_q - mod_rsp.rem : '0;
    srec1 = NW'(srec_q + 30'd1);

    used_b  = used_q[bk];
    first_b = first_q[bk];
    last_b  = last_q[bk];
    idx_w   = RW'(ls_q) + RW'(exr_q);

    space_last = (IW'(nrec_q) > ls_q) ? AW'(IW'(nrec_q) - ls_q) << 3 : '0;
    space_gap  = (IW'(nxt_q) > ls_q) ? AW'(IW'(nxt_q) - ls_q) << 3 : '0;
  end

  function automatic logic [31:0] daddr(input logic [31:0] s, input logic [RW-1:0] i);
    return s + ((32'(i) + 32'd1) << 3);
  endfunction

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    req_d       = req_q;
    bank_d      = bank_q;
    start_d     = start_q;
    nrec_d      = nrec_q;
    align_d     = align_q;
    srec_d      = srec_q;
    need_d      = need_q;
    exr_d       = exr_q;
    ls_d        = ls_q;
    cur_d       = cur_q;
    nxt_d       = nxt_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    target_d    = target_q;
    tf_d        = tf_q;
    rstat_d     = rstat_q;
    raddr_d     = raddr_q;
    out_rsp_d   = out_rsp_q;
    out_valid_d = out_valid_q && !out_ready_i;
    used_d      = used_q;
    first_d     = first_q;
    last_d      = last_q;
    next_we     = 1'b0;
    next_wa     = slot(bank_q, cur_q);
    next_wd     = '0;
    next_ra     = slot(bank_q, cur_q);
    size_we     = 1'b0;
    size_wa     = slot(bank_q, idx_w);
    size_wd     = srec1;
    size_ra     = slot(bank_q, cur_q);
    mod_req     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_req_i;
          rstat_d = ST_OK;
          raddr_d = '0;
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        bank_d  = bk;
        start_d = bk_start;
        if (req_q.req_type == REQ_FREE) begin
          state_d = S_DONE;
          if (!hit) begin
            rstat_d = ST_NOBANK;
          end else if (!used_b) begin
            rstat_d = ST_OK;
          end else if (first_b == last_b) begin
            used_d[bk]  = 1'b0;
            first_d[bk] = '0;
            last_d[bk]  = '0;
          end else if (off >= 32'd8) begin
            target_d = off[31:3] - 29'd1;
            tf_d     = (off[31:3] - 29'd1) == TW'(first_b);
            cur_d    = first_b;
            cnt_d    = '0;
            state_d  = S_FW_RD;
          end
        end else if (req_q.size_bytes == '0 || 32'(req_q.bank) >= BANKS) begin
          rstat_d = ST_FAIL;
          state_d = S_DONE;
        end else begin
          nrec_d           = nrec_w;
          align_d          = align_w;
          srec_d           = srec_w;
          mod_req.start    = 1'b1;
          mod_req.dividend = AW'(bk_start) + AW'(8);
          mod_req.divisor  = align_w;
          phase_d          = PH_FIRST;
          state_d          = S_MODW;
        end
      end

      S_MODW: begin
        if (mod_rsp.done) begin
          state_d = S_NEED;
        end
      end

      S_NEED: begin
        need_d = sz_w + AW'(ex_w) + AW'(8);
        exr_d  = 17'(ex_w >> 3);
        case (phase_q)
          PH_FIRST: state_d = S_CHK_FIRST;
          PH_LAST:  state_d = S_CHK_LAST;
          default:  state_d = S_CHK_GAP;
        endcase
      end

      S_CHK_FIRST: begin
        size_wa = slot(bank_q, RW'(exr_q));
        next_wa = slot(bank_q, RW'(exr_q));
        next_wd = first_b;
        if (!used_b) begin
          state_d = S_DONE;
          if ((AW'(nrec_q) << 3) >= need_q) begin
            size_we         = 1'b1;
            first_d[bank_q] = RW'(exr_q);
            last_d[bank_q]  = RW'(exr_q);
            used_d[bank_q]  = 1'b1;
            raddr_d         = daddr(start_q, RW'(exr_q));
          end else begin
            rstat_d = ST_FAIL;
          end
        end else if ((AW'(first_b) << 3) >= need_q) begin
          size_we         = 1'b1;
          next_we         = 1'b1;
          first_d[bank_q] = RW'(exr_q);
          raddr_d         = daddr(start_q, RW'(exr_q));
          state_d         = S_DONE;
        end else begin
          state_d = S_RD_LAST;
        end
      end

      S_RD_LAST: begin
        size_ra = slot(bank_q, last_b);
        state_d = S_LAST_DAT;
      end

      S_LAST_DAT: begin
        ls_d             = IW'(last_b) + IW'(size_rd_q);
        mod_req.start    = 1'b1;
        mod_req.dividend = AW'(start_q) + ((AW'(last_b) + AW'(size_rd_q) + AW'(1)) << 3);
        mod_req.divisor  = align_q;
        phase_d          = PH_LAST;
        state_d          = S_MODW;
      end

      S_CHK_LAST: begin
        if (space_last >= need_q) begin
          next_we        = 1'b1;
          next_wa        = slot(bank_q, last_b);
          next_wd        = idx_w;
          size_we        = 1'b1;
          last_d[bank_q] = idx_w;
          raddr_d        = daddr(start_q, idx_w);
          state_d        = S_DONE;
        end else begin
          cur_d   = first_b;
          cnt_d   = '0;
          state_d = S_WLK_RD;
        end
      end

      S_WLK_RD: begin
        if (cnt_q < NW'(MAX_RECORDS) && cur_q < last_b) begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_WLK_DAT;
        end else begin
          rstat_d = ST_FAIL;
          state_d = S_DONE;
        end
      end

      S_WLK_DAT: begin
        nxt_d            = next_rd_q;
        ls_d             = IW'(cur_q) + IW'(size_rd_q);
        mod_req.start    = 1'b1;
        mod_req.dividend = AW'(start_q) + ((AW'(cur_q) + AW'(size_rd_q) + AW'(1)) << 3);
        mod_req.divisor  = align_q;
        phase_d          = PH_GAP;
        state_d          = S_MODW;
      end

      S_CHK_GAP: begin
        if (space_gap >= need_q) begin
          idx_d   = idx_w;
          size_we = 1'b1;
          next_we = 1'b1;
          next_wa = slot(bank_q, idx_w);
          next_wd = nxt_q;
          raddr_d = daddr(start_q, idx_w);
          state_d = S_GAP_WR2;
        end else begin
          cur_d   = nxt_q;
          state_d = S_WLK_RD;
        end
      end

      S_GAP_WR2: begin
        next_we = 1'b1;
        next_wd = idx_q;
        state_d = S_DONE;
      end

      S_FW_RD: begin
        if (cnt_q < NW'(MAX_RECORDS)) begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_FW_DAT;
        end else begin
          state_d = S_DONE;
        end
      end

      S_FW_DAT: begin
        if (tf_q) begin
          first_d[bank_q] = next_rd_q;
          state_d         = S_DONE;
        end else if (TW'(next_rd_q) == target_q) begin
          if (target_q == TW'(last_b)) begin
            last_d[bank_q] = cur_q;
            state_d        = S_DONE;
          end else begin
            state_d = S_FT_RD;
          end
        end else begin
          cur_d   = next_rd_q;
          state_d = S_FW_RD;
        end
      end

      S_FT_RD: begin
        // read index of the target is cut to RW bits; it wraps at the record count only when that is a power of two
        next_ra = slot(bank_q, RW'(target_q));
        state_d = S_FT_DAT;
      end

      S_FT_DAT: begin
        next_we = 1'b1;
        next_wd = next_rd_q;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d            = 1'b1;
          out_rsp_d.status       = rstat_q;
          out_rsp_d.data_address = (rstat_q == ST_OK) ? raddr_q : '0;
          state_d                = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int k = 0; k < BANKS; k++) begin
        used_q[k]  <= 1'b0;
        first_q[k] <= '0;
        last_q[k]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      used_q      <= used_d;
      first_q     <= first_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q   <= phase_d;
    req_q     <= req_d;
    bank_q    <= bank_d;
    start_q   <= start_d;
    nrec_q    <= nrec_d;
    align_q   <= align_d;
    srec_q    <= srec_d;
    need_q    <= need_d;
    exr_q     <= exr_d;
    ls_q      <= ls_d;
    cur_q     <= cur_d;
    nxt_q     <= nxt_d;
    idx_q     <= idx_d;
    cnt_q     <= cnt_d;
    target_q  <= target_d;
    tf_q      <= tf_d;
    rstat_q   <= rstat_d;
    raddr_q   <= raddr_d;
    out_rsp_q <= out_rsp_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

[rtl/affa_mod.sv]
// Bit-serial remainder unit, one dividend bit per cycle.
module affa_mod import affa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mod_req_t req_i,
  output mod_rsp_t rsp_o
);

  localparam int unsigned CW = $clog2(AW + 1);

  logic [AW-1:0]   shf_q, shf_d;
  logic [DV_W-1:0] rem_q, rem_d, div_q, div_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            run_q, run_d, done_q, done_d;
  logic [DV_W:0]   trial;

  always_comb begin
    shf_d  = shf_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    trial  = {rem_q, shf_q[AW-1]};
    if (req_i.start) begin
      shf_d = req_i.dividend;
      rem_d = '0;
      div_d = req_i.divisor;
      cnt_d = CW'(AW);
      run_d = 1'b1;
    end else if (run_q) begin
      // rem < divisor, so trial < 2*divisor: one subtract restores it
      if (trial >= {1'b0, div_q}) begin
        rem_d = DV_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[DV_W-1:0];
      end
      shf_d = shf_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shf_q <= shf_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

[rtl/affa_checker.sv]
// Port-level checks for the allocator, bound to the top level.
module affa_checker import affa_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input rsp_t out_rsp_o
);

  // one request in flight: ready drops right after a request is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after a request was taken");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled response changed");

  a_fail_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status != ST_OK |-> out_rsp_o.data_address == '0)
    else $error("failed response carries an address");

endmodule

bind aligned_first_fit_chunk_allocator affa_checker u_affa_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for the aligned first-fit chunk allocator.
`timescale 1ns / 100ps

module testbench;
  import affa_pkg::*;

  localparam int NREC  = MAX_RECORDS_DEF;
  localparam int NBANK = BANKS_DEF;
  localparam int SLOTS = NBANK * NREC;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #5 clk = ~clk;

  aligned_first_fit_chunk_allocator dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_rsp_o(out_rsp),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // heap mirror
  logic [31:0]       bank_reg [8];
  longint unsigned   head_idx [NBANK];
  longint unsigned   tail_idx [NBANK];
  bit                bank_busy [NBANK];
  longint unsigned   link_mem [SLOTS];
  longint unsigned   size_mem [SLOTS];
  bit                link_set [SLOTS];
  bit                size_set [SLOTS];
  bit                stale_read;

  rsp_t rsp_q[$];
  int   fail_cnt = 0;
  int   rsp_cnt = 0;
  int   n_alloc_ok = 0, n_alloc_fail = 0, n_free = 0, n_nobank = 0;
  int   burst_left = 4;

  function automatic longint unsigned bstart(int b);
    return longint'(bank_reg[2*b]);
  endfunction

  function automatic longint unsigned bend(int b);
    return longint'(bank_reg[2*b+1]);
  endfunction

  function automatic longint unsigned brecs(int b);
    longint unsigned s, e, n;
    s = bstart(b);
    e = bend(b);
    if (e <= s) return 0;
    n = (e - s) / 8;
    return (n > NREC) ? NREC : n;
  endfunction

  function automatic int sl(int b, longint unsigned i);
    return b * NREC + int'(i % NREC);
  endfunction

  function automatic longint unsigned get_link(int b, longint unsigned i);
    if (!link_set[sl(b, i)]) stale_read = 1'b1;
    return link_mem[sl(b, i)];
  endfunction

  function automatic longint unsigned get_size(int b, longint unsigned i);
    if (!size_set[sl(b, i)]) stale_read = 1'b1;
    return size_mem[sl(b, i)];
  endfunction

  function automatic void put_link(int b, longint unsigned i, longint unsigned v);
    link_mem[sl(b, i)] = v & 32'hFFFF_FFFF;
    link_set[sl(b, i)] = 1'b1;
  endfunction

  function automatic void put_size(int b, longint unsigned i, longint unsigned v);
    size_mem[sl(b, i)] = v & 32'hFFFF_FFFF;
    size_set[sl(b, i)] = 1'b1;
  endfunction

  function automatic longint unsigned pad(longint unsigned ds, longint unsigned al);
    longint unsigned r;
    r = ds % al;
    return (r != 0) ? al - r : 0;
  endfunction

  function automatic bit heap_alloc(longint unsigned size, int b, longint unsigned alg,
                                    output longint unsigned addr);
    longint unsigned a, g, x, t, al, srec, sz, st, nrec, ex, idx, f, l, s, cur, nxt, space;
    addr = 0;
    if (size == 0 || b >= NBANK) return 0;
    a = (alg != 0) ? alg : 1;
    g = a;
    x = 8;
    while (x != 0) begin
      t = g % x;
      g = x;
      x = t;
    end
    al = a * 8 / g;
    srec = (size + 7) / 8;
    sz = srec * 8;
    st = bstart(b);
    nrec = brecs(b);
    ex = pad(st + 8, al);
    if (!bank_busy[b]) begin
      if (nrec * 8 < sz + ex + 8) return 0;
      idx = ex / 8;
      put_size(b, idx, srec + 1);
      head_idx[b] = idx;
      tail_idx[b] = idx;
      bank_busy[b] = 1'b1;
      addr = st + (idx + 1) * 8;
      return 1;
    end
    f = head_idx[b];
    if (f * 8 >= sz + ex + 8) begin
      idx = ex / 8;
      put_link(b, idx, f);
      put_size(b, idx, srec + 1);
      head_idx[b] = idx;
      addr = st + (idx + 1) * 8;
      return 1;
    end
    l = tail_idx[b];
    s = get_size(b, l);
    ex = pad(st + (l + s + 1) * 8, al);
    space = (nrec > l + s) ? (nrec - l - s) * 8 : 0;
    if (space >= sz + ex + 8) begin
      idx = l + s + ex / 8;
      put_link(b, l, idx % NREC);
      put_size(b, idx, srec + 1);
      tail_idx[b] = idx % NREC;
      addr = st + (idx + 1) * 8;
      return 1;
    end
    cur = f;
    for (int n = 0; n < NREC && cur < l; n++) begin
      nxt = get_link(b, cur);
      s = get_size(b, cur);
      ex = pad(st + (cur + s + 1) * 8, al);
      space = (nxt > cur + s) ? (nxt - cur - s) * 8 : 0;
      if (space >= sz + ex + 8) begin
        idx = cur + s + ex / 8;
        put_size(b, idx, srec + 1);
        put_link(b, idx, nxt);
        put_link(b, cur, idx % NREC);
        addr = st + (idx + 1) * 8;
        return 1;
      end
      cur = nxt;
    end
    return 0;
  endfunction

  function automatic status_e heap_free(longint unsigned pa);
    int b;
    bit hit, found;
    longint unsigned off, tgt, i, nx;
    hit = 0;
    found = 0;
    b = 0;
    for (int k = 0; k < NBANK; k++) begin
      if (!hit && bstart(k) <= pa && bend(k) > pa) begin
        hit = 1;
        b = k;
      end
    end
    if (!hit) return ST_NOBANK;
    if (!bank_busy[b]) return ST_OK;
    if (head_idx[b] == tail_idx[b]) begin
      bank_busy[b] = 0;
      head_idx[b] = 0;
      tail_idx[b] = 0;
      return ST_OK;
    end
    off = pa - bstart(b);
    if (off < 8) return ST_OK;
    tgt = off / 8 - 1;
    if (tgt == head_idx[b]) begin
      head_idx[b] = get_link(b, head_idx[b]);
      return ST_OK;
    end
    i = head_idx[b];
    for (int n = 0; n < NREC && !found; n++) begin
      nx = get_link(b, i);
      if (nx == tgt) found = 1;
      else i = nx;
    end
    if (!found) return ST_OK;
    if (tgt == tail_idx[b]) tail_idx[b] = i;
    else put_link(b, i, get_link(b, tgt));
    return ST_OK;
  endfunction

  function automatic rsp_t heap_predict(req_t r);
    rsp_t o;
    longint unsigned addr;
    bit ok;
    o = '0;
    if (r.req_type == REQ_FREE) begin
      o.status = heap_free(longint'(r.address));
    end else begin
      ok = heap_alloc(longint'(r.size_bytes), int'(r.bank), longint'(r.alignment), addr);
      o.status = ok ? ST_OK : ST_FAIL;
      o.data_address = ok ? addr[31:0] : 32'h0;
    end
    return o;
  endfunction

  // data address of a random live chunk; 0 if no bank holds any
  function automatic bit live_chunk(output logic [31:0] addr);
    longint unsigned chain[$];
    longint unsigned i;
    int b0, b;
    addr = 0;
    b0 = $urandom_range(0, NBANK - 1);
    for (int k = 0; k < NBANK; k++) begin
      b = (b0 + k) % NBANK;
      if (bank_busy[b]) begin
        i = head_idx[b];
        chain.push_back(i);
        for (int n = 0; n < NREC && i != tail_idx[b]; n++) begin
          i = link_mem[sl(b, i)];
          chain.push_back(i);
        end
        i = chain[$urandom_range(0, chain.size() - 1)];
        addr = 32'(bstart(b) + (i + 1) * 8);
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int b, c;
    longint unsigned mx;
    logic [31:0] a;
    r.req_type = REQ_ALLOC;
    r.size_bytes = $urandom;
    r.bank = $urandom_range(0, 3);
    r.alignment = $urandom_range(0, 65536);
    r.address = $urandom;
    if ($urandom_range(0, 99) < 45 && live_chunk(a)) begin
      r.req_type = REQ_FREE;
      c = $urandom_range(0, 9);
      b = $urandom_range(0, NBANK - 1);
      if (c < 7) r.address = a;
      else if (c == 7) r.address = bank_reg[2*b] + $urandom_range(0, 7);
      else if (c == 8) r.address = 32'(bstart(b) + $urandom_range(0, int'(brecs(b)) * 8));
      return r;
    end
    c = $urandom_range(0, 19);
    mx = brecs(int'(r.bank)) * 8 / 5;
    if (mx < 8) mx = 8;
    if (c == 0) r.size_bytes = 0;
    else if (c == 1) r.size_bytes = $urandom;
    else if (c == 2) r.size_bytes = $urandom_range(1, 8);
    else r.size_bytes = $urandom_range(1, int'(mx));
    c = $urandom_range(0, 9);
    if (c == 0) r.alignment = 0;
    else if (c == 1) r.alignment = 17'd65536;
    else if (c > 3) r.alignment = 17'(1 << $urandom_range(0, 6));
    return r;
  endfunction

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_req(req_t r);
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
  endtask

  // predict, swapping out a request that would walk into never-written headers
  task automatic issue(req_t r, bit typed, rsp_t typed_rsp);
    longint unsigned sv_head [NBANK], sv_tail [NBANK];
    bit sv_busy [NBANK];
    longint unsigned sv_link [SLOTS], sv_size [SLOTS];
    bit sv_lset [SLOTS], sv_sset [SLOTS];
    rsp_t p;
    logic [31:0] a;
    sv_head = head_idx; sv_tail = tail_idx; sv_busy = bank_busy;
    sv_link = link_mem; sv_size = size_mem; sv_lset = link_set; sv_sset = size_set;
    stale_read = 0;
    p = heap_predict(r);
    if (stale_read) begin
      head_idx = sv_head; tail_idx = sv_tail; bank_busy = sv_busy;
      link_mem = sv_link; size_mem = sv_size; link_set = sv_lset; size_set = sv_sset;
      typed = 0;
      if (live_chunk(a)) begin
        r.req_type = REQ_FREE;
        r.address = a;
      end else begin
        r.req_type = REQ_ALLOC;
        r.size_bytes = 8;
      end
      p = heap_predict(r);
    end
    if (r.req_type == REQ_FREE) begin
      if (p.status == ST_NOBANK) n_nobank++;
      else n_free++;
    end else if (p.status == ST_OK) n_alloc_ok++;
    else n_alloc_fail++;
    rsp_q.push_back(typed ? typed_rsp : p);
    send_req(r);
  endtask

  task automatic wait_drain();
    drop_valid();
    while (rsp_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_bank(cfg_idx_e idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    bank_reg[idx] = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_banks(logic [31:0] v [8]);
    for (int k = 0; k < 8; k++) write_bank(cfg_idx_e'(k), v[k]);
  endtask

  function automatic req_t mk(logic t, logic [31:0] sz, logic [1:0] b, logic [16:0] al,
                              logic [31:0] ad);
    req_t r;
    r.req_type = t;
    r.size_bytes = sz;
    r.bank = b;
    r.alignment = al;
    r.address = ad;
    return r;
  endfunction

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t e;
  } dir_row_t;

  localparam rsp_t R_OK   = '{status: ST_OK,     data_address: 32'h0};
  localparam rsp_t R_FAIL = '{status: ST_FAIL,   data_address: 32'h0};
  localparam rsp_t R_NOB  = '{status: ST_NOBANK, data_address: 32'h0};

  // response checker
  always @(posedge clk) begin
    rsp_t e;
    if (rst_n && out_valid && out_ready) begin
      rsp_cnt++;
      if (rsp_q.size() == 0) begin
        $error("response with none pending: status %0d addr %h",
               out_rsp.status, out_rsp.data_address);
        fail_cnt++;
      end else begin
        e = rsp_q.pop_front();
        if (out_rsp.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_rsp.status);
          fail_cnt++;
        end
        if (out_rsp.data_address !== e.data_address) begin
          $error("data_address: expected %h, got %h", e.data_address, out_rsp.data_address);
          fail_cnt++;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int mode, seg;
    bit held;
    held = 0;
    @(posedge rst_n);
    forever begin
      if (!held && rsp_cnt >= 200) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      mode = $urandom_range(0, 2);
      seg = $urandom_range(10, 60);
      repeat (seg) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    #200ms;
    $display("timeout with %0d responses pending", rsp_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    dir_row_t dir [$];
    logic [31:0] cfg_a [8] = '{32'h1000, 32'h1200, 32'h2000, 32'h2100,
                               32'h8000, 32'h8000, 32'hFFFF_FE00, 32'hFFFF_FFFF};
    // huge bank 0, unaligned bank 1, bank 2 inside bank 0, bank 3 reversed
    logic [31:0] cfg_b [8] = '{32'h0, 32'hFFFF_FFFF, 32'h0010_0004, 32'h0010_0204,
                               32'h4000, 32'h4400, 32'h9000, 32'h8000};
    logic [31:0] cfg_c [8] = '{32'h10, 32'h30, 32'h3000, 32'h3400,
                               32'h0, 32'h0, 32'h7FFF_FF00, 32'h8000_0000};
    head_idx = '{default: 0};
    tail_idx = '{default: 0};
    bank_busy = '{default: 0};
    bank_reg = '{default: 0};
    for (int k = 0; k < SLOTS; k++) begin
      link_mem[k] = 0; size_mem[k] = 0; link_set[k] = 0; size_set[k] = 0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_banks(cfg_a);
    dir.push_back('{mk(REQ_ALLOC, 0, 0, 8, $urandom), 1, R_FAIL});
    dir.push_back('{mk(REQ_FREE, $urandom, 0, 8, 32'h0), 1, R_NOB});
    dir.push_back('{mk(REQ_FREE, 0, 0, 0, 32'h1010), 1, R_OK});
    dir.push_back('{mk(REQ_ALLOC, 8, 0, 8, 0), 1, '{ST_OK, 32'h1008}});
    dir.push_back('{mk(REQ_ALLOC, 16, 0, 0, 0), 0, R_OK});
    dir.push_back('{mk(REQ_ALLOC, 24, 0, 3, 0), 0, R_OK});
    dir.push_back('{mk(REQ_ALLOC, 1, 0, 17'd65536, 0), 0, R_OK});
    dir.push_back('{mk(REQ_ALLOC, 32'hFFFF_FFFF, 0, 8, 0), 1, R_FAIL});
    dir.push_back('{mk(REQ_ALLOC, 8, 2, 8, 0), 1, R_FAIL});
    dir.push_back('{mk(REQ_ALLOC, 8, 3, 1, 0), 0, R_OK});
    dir.push_back('{mk(REQ_FREE, 0, 0, 0, 32'h1008), 1, R_OK});
    dir.push_back('{mk(REQ_FREE, 0, 0, 0, 32'h1001), 1, R_OK});
    dir.push_back('{mk(REQ_ALLOC, 8, 0, 8, 0), 0, R_OK});
    dir.push_back('{mk(REQ_FREE, 0, 0, 0, 32'h1018), 1, R_OK});
    dir.push_back('{mk(REQ_FREE, 0, 0, 0, 32'hFFFF_FE08), 1, R_OK});
    dir.push_back('{mk(REQ_ALLOC, 1, 1, 16, 0), 0, R_OK});
    dir.push_back('{mk(REQ_FREE, 0, 0, 0, 32'h2004), 1, R_OK});
    dir.push_back('{mk(REQ_ALLOC, 64, 0, 128, 0), 0, R_OK});
    dir.push_back('{mk(REQ_ALLOC, 400, 0, 8, 0), 0, R_OK});
    dir.push_back('{mk(REQ_FREE, 0, 0, 0, 32'hFFFF_FFFF), 1, R_NOB});
    foreach (dir[k]) issue(dir[k].r, dir[k].typed, dir[k].e);

    for (int n = 0; n < 300; n++) issue(rand_req(), 0, R_OK);
    wait_drain();
    load_banks(cfg_b);
    for (int n = 0; n < 300; n++) begin
      if (n == 150) begin
        drop_valid();
        while (rsp_q.size() != 0) @(posedge clk);
      end
      issue(rand_req(), 0, R_OK);
    end
    wait_drain();
    load_banks(cfg_c);
    for (int n = 0; n < 250; n++) issue(rand_req(), 0, R_OK);
    wait_drain();

    if (rsp_q.size() != 0) begin
      $error("%0d responses never arrived", rsp_q.size());
      fail_cnt++;
    end
    $display("covered: %0d allocations granted, %0d refused, %0d frees, %0d outside banks",
             n_alloc_ok, n_alloc_fail, n_free, n_nobank);
    $display("three bank layouts, %0d responses checked, %0d mismatches", rsp_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
